FILE: hw/rtl/small_matrix_arith_unit_defines.svh
// small_matrix_arith_unit_defines.svh: assertion macros
`ifndef SMALL_MATRIX_ARITH_UNIT_DEFINES_SVH
`define SMALL_MATRIX_ARITH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SMAU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMAU_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMAU_ASSERT(label, clk, rst_n, prop, msg)
`define SMAU_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/smau_pkg.sv
// ----------------------------------------------------------------------------
// smau_pkg
// Shared codes of the small matrix arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package smau_pkg;
  localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DET = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIM      = 2'd1;
  localparam logic [1:0] ST_DET_SIZE = 2'd2;

  localparam logic [2:0] REG_ROWS_A = 3'd0;
  localparam logic [2:0] REG_COLS_A = 3'd1;
  localparam logic [2:0] REG_ROWS_B = 3'd2;
  localparam logic [2:0] REG_COLS_B = 3'd3;
  localparam logic [2:0] REG_OP     = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RDA   = 6'b000010,
    S_RDB   = 6'b000100,
    S_MAC   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_e;
endpackage

FILE: hw/rtl/small_matrix_arith_unit.sv
// ----------------------------------------------------------------------------
// small_matrix_arith_unit
// Integer matrix add, subtract, multiply and 1x1..3x3 determinant.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low first)              | tuser
// s_axis  | in  | value[31:0]                           | func[1:0]
// m_axis  | out | status, row_index, col_index, result  | - ; tlast = last
// cfg     | in  | wr_en_i, wr_idx_i, wr_data_i          | -
// Loads and error computes complete in idle. Compute uses 32x32 multiplies and
// an adder: each term steps through read A, read B and accumulate, and each
// result through an emit state; a wait state follows the last beat. Emit
// holds while the output register is full, and input ready drops while busy
// or while a result beat waits. Reset clears the fill counts, registers and
// sequencer; stores are not cleared.
`timescale 1ns / 1ps
`include "small_matrix_arith_unit_defines.svh"
module small_matrix_arith_unit #(
  parameter int MAX_DIM = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status[1:0] row[3:2] col[5:4] value[37:6] zero
  output logic        m_axis_tlast,
  input  logic        wr_en_i,
  input  logic [2:0]  wr_idx_i,
  input  logic [2:0]  wr_data_i
);
  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FW = $clog2(Depth + 1);

  logic [31:0] mem_a [Depth];
  logic [31:0] mem_b [Depth];
  logic [FW-1:0] fill_a_q, fill_b_q;
  logic [2:0] ra_q, ca_q, rb_q, cb_q;
  logic [1:0] op_q;
  smau_pkg::state_e st_q;
  logic [2:0] r_q, c_q, k_q, nr_q, nc_q;
  logic [4:0] t_q;           // determinant term / factor step
  logic [2:0] trm_q;         // 3x3 product term
  logic [1:0] fct_q;         // factor within the term
  logic [31:0] acc_q, prod_q, da_q, db_q;
  logic [AW-1:0] addr_a, addr_b;
  logic ov_a, ov_b;
  logic vld_q, last_q;
  logic [1:0] sts_q, ro_q, co_q;
  logic [31:0] res_q;

  // determinant factor table: term (0..5) factor (0..2) -> (row,col)
  logic [3:0] dr, dc;
  always_comb begin
    logic [3:0] sel;
    sel = 4'd0;
    case (trm_q)
      3'd0: sel = (fct_q == 2'd0) ? 4'h0 : (fct_q == 2'd1) ? 4'h5 : 4'ha;
      3'd1: sel = (fct_q == 2'd0) ? 4'h1 : (fct_q == 2'd1) ? 4'h6 : 4'h8;
      3'd2: sel = (fct_q == 2'd0) ? 4'h2 : (fct_q == 2'd1) ? 4'h4 : 4'h9;
      3'd3: sel = (fct_q == 2'd0) ? 4'h2 : (fct_q == 2'd1) ? 4'h5 : 4'h8;
      3'd4: sel = (fct_q == 2'd0) ? 4'h1 : (fct_q == 2'd1) ? 4'h4 : 4'ha;
      default: sel = (fct_q == 2'd0) ? 4'h0 : (fct_q == 2'd1) ? 4'h6 : 4'h9;
    endcase
    dr = {2'b00, sel[3:2]};
    dc = {2'b00, sel[1:0]};
  end

  // 2x2 det uses terms (0,0)(1,1) and (0,1)(1,0): t 0..1 plus, 2..3 minus
  logic [3:0] er, ec;
  logic det2;
  assign det2 = (ra_q == 3'd2);
  always_comb begin
    er = dr;
    ec = dc;
    if (det2) begin
      case (t_q[1:0])
        2'd0: begin er = 4'd0; ec = 4'd0; end
        2'd1: begin er = 4'd1; ec = 4'd1; end
        2'd2: begin er = 4'd0; ec = 4'd1; end
        default: begin er = 4'd1; ec = 4'd0; end
      endcase
    end else if (ra_q == 3'd1) begin
      er = 4'd0;
      ec = 4'd0;
    end
  end

  logic [6:0] ia, ib;
  logic det_mode;
  assign det_mode = (op_q == smau_pkg::OP_DET);
  always_comb begin
    if (det_mode) ia = 7'(er) * 7'(ca_q) + 7'(ec);
    else if (op_q == smau_pkg::OP_MUL) ia = 7'(r_q) * 7'(ca_q) + 7'(k_q);
    else ia = 7'(r_q) * 7'(ca_q) + 7'(c_q);
    if (op_q == smau_pkg::OP_MUL) ib = 7'(k_q) * 7'(cb_q) + 7'(c_q);
    else ib = 7'(r_q) * 7'(cb_q) + 7'(c_q);
    ov_a = (ia >= 7'(Depth));
    ov_b = (ib >= 7'(Depth));
    addr_a = AW'(ia);
    addr_b = AW'(ib);
  end

  // shape checks
  logic dims_ok, shape_ok, det_ok;
  always_comb begin
    dims_ok = (ra_q >= 3'd1) && (32'(ra_q) <= MAX_DIM) && (ca_q >= 3'd1) &&
              (32'(ca_q) <= MAX_DIM) && (rb_q >= 3'd1) && (32'(rb_q) <= MAX_DIM) &&
              (cb_q >= 3'd1) && (32'(cb_q) <= MAX_DIM);
    shape_ok = (op_q == smau_pkg::OP_MUL) ? (ca_q == rb_q)
                                         : (ra_q == rb_q && ca_q == cb_q);
    det_ok = (ra_q == ca_q) && (ra_q <= 3'd3);
  end

  logic out_free;
  assign out_free = !vld_q || m_axis_tready;
  assign s_axis_tready = (st_q == smau_pkg::S_IDLE) && out_free;
  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  logic emit_err, emit_ok;
  assign emit_err = acc_in && (s_axis_tuser == smau_pkg::FUNC_COMPUTE) &&
                    (!dims_ok || (det_mode ? !det_ok : !shape_ok));
  assign emit_ok = (st_q == smau_pkg::S_EMIT) && out_free;

  always_ff @(posedge clk_i) begin
    if (acc_in && s_axis_tuser == smau_pkg::FUNC_LOAD_A && 32'(fill_a_q) < Depth)
      mem_a[AW'(fill_a_q)] <= s_axis_tdata;
    if (acc_in && s_axis_tuser == smau_pkg::FUNC_LOAD_B && 32'(fill_b_q) < Depth)
      mem_b[AW'(fill_b_q)] <= s_axis_tdata;
    if (st_q == smau_pkg::S_RDA) da_q <= ov_a ? 32'd0 : mem_a[addr_a];
    if (st_q == smau_pkg::S_RDB) db_q <= ov_b ? 32'd0 : mem_b[addr_b];
  end

  // step counts
  logic [4:0] det_steps;
  assign det_steps = (ra_q == 3'd1) ? 5'd1 : (ra_q == 3'd2) ? 5'd4 : 5'd18;
  logic det_pos_end;  // last factor of a product term
  assign det_pos_end = (ra_q == 3'd1) ? 1'b1 : det2 ? t_q[0] : (fct_q == 2'd2);
  logic det_neg;
  assign det_neg = det2 ? t_q[1] : (trm_q >= 3'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= smau_pkg::S_IDLE;
      fill_a_q <= '0; fill_b_q <= '0;
      ra_q <= 3'd1; ca_q <= 3'd1; rb_q <= 3'd1; cb_q <= 3'd1; op_q <= 2'd0;
      vld_q <= 1'b0;
      r_q <= '0; c_q <= '0; k_q <= '0; t_q <= '0; nr_q <= '0; nc_q <= '0;
      trm_q <= '0; fct_q <= '0;
      acc_q <= '0; prod_q <= '0;
      last_q <= 1'b0; sts_q <= '0; ro_q <= '0; co_q <= '0; res_q <= '0;
    end else begin
      if (emit_err || emit_ok) vld_q <= 1'b1;
      else if (m_axis_tready) vld_q <= 1'b0;
      if (wr_en_i) begin
        unique case (wr_idx_i)
          smau_pkg::REG_ROWS_A: ra_q <= wr_data_i;
          smau_pkg::REG_COLS_A: ca_q <= wr_data_i;
          smau_pkg::REG_ROWS_B: rb_q <= wr_data_i;
          smau_pkg::REG_COLS_B: cb_q <= wr_data_i;
          smau_pkg::REG_OP:     op_q <= wr_data_i[1:0];
          default: ;
        endcase
      end
      unique case (st_q)
        smau_pkg::S_IDLE: begin
          if (acc_in) begin
            case (s_axis_tuser)
              smau_pkg::FUNC_LOAD_A:
                if (32'(fill_a_q) < Depth) fill_a_q <= fill_a_q + 1'b1;
              smau_pkg::FUNC_LOAD_B:
                if (32'(fill_b_q) < Depth) fill_b_q <= fill_b_q + 1'b1;
              smau_pkg::FUNC_COMPUTE: begin
                fill_a_q <= '0; fill_b_q <= '0;
                r_q <= '0; c_q <= '0; k_q <= '0; t_q <= '0;
                trm_q <= '0; fct_q <= '0;
                acc_q <= '0; prod_q <= 32'd1;
                nr_q <= ra_q;
                nc_q <= (op_q == smau_pkg::OP_MUL) ? cb_q : ca_q;
                if (!dims_ok || (!det_mode && !shape_ok)) begin
                  sts_q <= smau_pkg::ST_DIM; ro_q <= '0; co_q <= '0;
                  res_q <= '0; last_q <= 1'b1;
                end else if (det_mode && !det_ok) begin
                  sts_q <= smau_pkg::ST_DET_SIZE; ro_q <= '0; co_q <= '0;
                  res_q <= '0; last_q <= 1'b1;
                end else st_q <= smau_pkg::S_RDA;
              end
              default: ;
            endcase
          end
        end
        smau_pkg::S_RDA: st_q <= smau_pkg::S_RDB;
        smau_pkg::S_RDB: st_q <= smau_pkg::S_MAC;
        smau_pkg::S_MAC: begin
          st_q <= smau_pkg::S_RDA;
          if (det_mode) begin
            if (det_pos_end) begin
              if (det_neg) acc_q <= acc_q - 32'(prod_q * da_q);
              else acc_q <= acc_q + 32'(prod_q * da_q);
              prod_q <= 32'd1;
            end else prod_q <= 32'(prod_q * da_q);
            t_q <= t_q + 1'b1;
            if (fct_q == 2'd2) begin
              fct_q <= '0;
              trm_q <= trm_q + 1'b1;
            end else fct_q <= fct_q + 1'b1;
            if (t_q + 5'd1 == det_steps) st_q <= smau_pkg::S_EMIT;
          end else if (op_q == smau_pkg::OP_MUL) begin
            acc_q <= acc_q + 32'(da_q * db_q);
            k_q <= k_q + 1'b1;
            if (k_q + 3'd1 == ca_q) st_q <= smau_pkg::S_EMIT;
          end else begin
            acc_q <= (op_q == smau_pkg::OP_ADD) ? da_q + db_q : da_q - db_q;
            st_q <= smau_pkg::S_EMIT;
          end
        end
        smau_pkg::S_EMIT: begin
          if (out_free) begin
            sts_q <= smau_pkg::ST_OK;
            ro_q <= det_mode ? 2'd0 : r_q[1:0];
            co_q <= det_mode ? 2'd0 : c_q[1:0];
            res_q <= acc_q;
            acc_q <= '0; k_q <= '0;
            if (det_mode || (c_q + 3'd1 == nc_q && r_q + 3'd1 == nr_q)) begin
              last_q <= 1'b1; st_q <= smau_pkg::S_WAIT;
            end else begin
              last_q <= 1'b0; st_q <= smau_pkg::S_RDA;
              if (c_q + 3'd1 == nc_q) begin c_q <= '0; r_q <= r_q + 1'b1; end
              else c_q <= c_q + 1'b1;
            end
          end
        end
        smau_pkg::S_WAIT: st_q <= smau_pkg::S_IDLE;
        default: st_q <= smau_pkg::S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tlast = last_q;
  assign m_axis_tdata = {2'b00, res_q, co_q, ro_q, sts_q};

  `SMAU_ASSERT(a_busy_not_ready, clk_i, rst_ni,
    (st_q != smau_pkg::S_IDLE) |-> !s_axis_tready, "ready while busy")
  `SMAU_ASSERT(a_fill_a_bound, clk_i, rst_ni,
    32'(fill_a_q) <= Depth, "fill A overflow")
  `SMAU_ASSERT(a_compute_clears, clk_i, rst_ni,
    (acc_in && s_axis_tuser == smau_pkg::FUNC_COMPUTE) |=> (fill_a_q == '0 && fill_b_q == '0),
    "fill not cleared")
  `SMAU_ASSERT_RST(a_reset_idle, clk_i,
    !rst_ni |=> (st_q == smau_pkg::S_IDLE), "not idle after reset")
endmodule

FILE: test/smau_checker.sv
// ----------------------------------------------------------------------------
// smau_checker
// Watches the config port and both streams of the matrix unit, predicts each
// result beat from its own copy of the registers and stores, and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smau_checker
  import smau_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        wr_en_i,
  input  logic [2:0]  wr_idx_i,
  input  logic [2:0]  wr_data_i,
  output int          fail_cnt_o,
  output int          pending_o
);
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        last;
  } elem_res_t;

  elem_res_t   result_q[$];
  logic [2:0]  rows_a, cols_a, rows_b, cols_b;
  logic [1:0]  op_sel;
  logic [31:0] mat_a[16];
  logic [31:0] mat_b[16];
  int          fill_a, fill_b;

  assign pending_o = result_q.size();

  function automatic logic [31:0] a_at(int r, int c);
    int idx;
    idx = r * cols_a + c;
    return (idx < 16) ? mat_a[idx] : 32'd0;
  endfunction

  function automatic logic [31:0] b_at(int r, int c);
    int idx;
    idx = r * cols_b + c;
    return (idx < 16) ? mat_b[idx] : 32'd0;
  endfunction

  function automatic bit dim_valid(logic [2:0] d);
    return d >= 3'd1 && d <= 3'd4;
  endfunction

  task automatic push_res(logic [1:0] st, int r, int c, logic [31:0] v, logic lst);
    elem_res_t e;
    e.status = st;
    e.row    = r[1:0];
    e.col    = c[1:0];
    e.value  = v;
    e.last   = lst;
    result_q.push_back(e);
  endtask

  task automatic predict_matrix_op();
    logic [31:0] acc, p, n;
    int          nr, nc;
    if (!dim_valid(rows_a) || !dim_valid(cols_a) || !dim_valid(rows_b) ||
        !dim_valid(cols_b)) begin
      push_res(ST_DIM, 0, 0, 32'd0, 1'b1);
      return;
    end
    if (op_sel == OP_DET) begin
      if (rows_a != cols_a || rows_a > 3'd3) begin
        push_res(ST_DET_SIZE, 0, 0, 32'd0, 1'b1);
      end else if (rows_a == 3'd1) begin
        push_res(ST_OK, 0, 0, a_at(0, 0), 1'b1);
      end else if (rows_a == 3'd2) begin
        acc = a_at(0, 0) * a_at(1, 1) - a_at(0, 1) * a_at(1, 0);
        push_res(ST_OK, 0, 0, acc, 1'b1);
      end else begin
        p = a_at(0, 0) * a_at(1, 1) * a_at(2, 2) + a_at(0, 1) * a_at(1, 2) * a_at(2, 0)
          + a_at(0, 2) * a_at(1, 0) * a_at(2, 1);
        n = a_at(0, 2) * a_at(1, 1) * a_at(2, 0) + a_at(0, 1) * a_at(1, 0) * a_at(2, 2)
          + a_at(0, 0) * a_at(1, 2) * a_at(2, 1);
        push_res(ST_OK, 0, 0, p - n, 1'b1);
      end
      return;
    end
    if (op_sel == OP_MUL) begin
      if (cols_a != rows_b) begin
        push_res(ST_DIM, 0, 0, 32'd0, 1'b1);
        return;
      end
      nr = rows_a;
      nc = cols_b;
    end else begin
      if (rows_a != rows_b || cols_a != cols_b) begin
        push_res(ST_DIM, 0, 0, 32'd0, 1'b1);
        return;
      end
      nr = rows_a;
      nc = cols_a;
    end
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (op_sel == OP_ADD) begin
          acc = a_at(r, c) + b_at(r, c);
        end else if (op_sel == OP_SUB) begin
          acc = a_at(r, c) - b_at(r, c);
        end else begin
          acc = 32'd0;
          for (int k = 0; k < cols_a; k++) acc += a_at(r, k) * b_at(k, c);
        end
        push_res(ST_OK, r, c, acc, (r + 1 == nr) && (c + 1 == nc));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    elem_res_t e;
    if (!rst_ni) begin
      rows_a = 3'd1;
      cols_a = 3'd1;
      rows_b = 3'd1;
      cols_b = 3'd1;
      op_sel = OP_ADD;
      fill_a = 0;
      fill_b = 0;
      fail_cnt_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat %h last %b", $time, m_axis_tdata,
                   m_axis_tlast);
          fail_cnt_o++;
        end else begin
          e = result_q.pop_front();
          if (m_axis_tdata[1:0] !== e.status || m_axis_tdata[3:2] !== e.row ||
              m_axis_tdata[5:4] !== e.col || m_axis_tdata[37:6] !== e.value ||
              m_axis_tlast !== e.last) begin
            $display("%0t: mismatch expected st %0d r %0d c %0d v %h last %b",
                     $time, e.status, e.row, e.col, e.value, e.last);
            $display("%0t:          actual   st %0d r %0d c %0d v %h last %b",
                     $time, m_axis_tdata[1:0], m_axis_tdata[3:2], m_axis_tdata[5:4],
                     m_axis_tdata[37:6], m_axis_tlast);
            fail_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          FUNC_LOAD_A: if (fill_a < 16) begin
            mat_a[fill_a] = s_axis_tdata;
            fill_a++;
          end
          FUNC_LOAD_B: if (fill_b < 16) begin
            mat_b[fill_b] = s_axis_tdata;
            fill_b++;
          end
          FUNC_COMPUTE: begin
            predict_matrix_op();
            fill_a = 0;
            fill_b = 0;
          end
          default: ;
        endcase
      end
      if (wr_en_i) begin
        case (wr_idx_i)
          REG_ROWS_A: rows_a = wr_data_i;
          REG_COLS_A: cols_a = wr_data_i;
          REG_ROWS_B: rows_b = wr_data_i;
          REG_COLS_B: cols_b = wr_data_i;
          REG_OP:     op_sel = wr_data_i[1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the matrix unit with directed and random load/compute runs under
// several shapes and operations, with random gaps and back-pressure; the
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import smau_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // value[31:0]
  logic [1:0]  s_axis_tuser = '0;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // status[1:0] row[3:2] col[5:4] value[37:6]
  logic        m_axis_tlast;
  logic        wr_en_i = 1'b0;
  logic [2:0]  wr_idx_i = '0;
  logic [2:0]  wr_data_i = '0;

  int          fail_cnt, pending;
  int          tx_idle_pct, rx_idle_pct, beat_cnt;
  int          fill_a, fill_b, top_a, top_b;
  bit          hold_req;
  logic [2:0]  rows_a, cols_a, rows_b, cols_b;
  logic [1:0]  op_sel;

  small_matrix_arith_unit dut (.*);

  smau_checker u_checker (
    .fail_cnt_o(fail_cnt),
    .pending_o (pending),
    .*
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = $urandom_range(99) >= rx_idle_pct;
      end
    end
  end

  function automatic bit dim_valid(logic [2:0] d);
    return d >= 3'd1 && d <= 3'd4;
  endfunction

  function automatic bit dims_valid();
    return dim_valid(rows_a) && dim_valid(cols_a) && dim_valid(rows_b) && dim_valid(cols_b);
  endfunction

  // entries of A read by a compute under the current setting
  function automatic int need_a();
    if (!dims_valid()) return 0;
    if (op_sel == OP_DET) return (rows_a == cols_a && rows_a <= 3) ? rows_a * cols_a : 0;
    if (op_sel == OP_MUL) return (cols_a == rows_b) ? rows_a * cols_a : 0;
    return (rows_a == rows_b && cols_a == cols_b) ? rows_a * cols_a : 0;
  endfunction

  function automatic int need_b();
    if (op_sel == OP_DET || need_a() == 0) return 0;
    return rows_b * cols_b;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return 32'hffff_ffff;
      4: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(logic [1:0] func, logic [31:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = func;
    s_axis_tdata  = val;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    beat_cnt++;
    if (func == FUNC_LOAD_A && fill_a < 16) begin
      fill_a++;
      if (fill_a > top_a) top_a = fill_a;
    end else if (func == FUNC_LOAD_B && fill_b < 16) begin
      fill_b++;
      if (fill_b > top_b) top_b = fill_b;
    end else if (func == FUNC_COMPUTE) begin
      fill_a = 0;
      fill_b = 0;
    end
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [2:0] data);
    wr_en_i   = 1'b1;
    wr_idx_i  = idx;
    wr_data_i = data;
    @(negedge clk_i);
    wr_en_i   = 1'b0;
  endtask

  task automatic set_shape(logic [2:0] ra, logic [2:0] ca, logic [2:0] rb, logic [2:0] cb,
                           logic [1:0] op);
    drain();
    write_reg(REG_ROWS_A, ra);
    write_reg(REG_COLS_A, ca);
    write_reg(REG_ROWS_B, rb);
    write_reg(REG_COLS_B, cb);
    write_reg(REG_OP, {1'b0, op});
    rows_a = ra;
    cols_a = ca;
    rows_b = rb;
    cols_b = cb;
    op_sel = op;
  endtask

  // one load-and-compute run; a broken run loads a short prefix and noise
  task automatic matrix_run(bit broken);
    int na, nb, ka, kb;
    na = need_a();
    nb = need_b();
    ka = broken ? $urandom_range(na) : na;
    kb = broken ? $urandom_range(nb) : nb;
    if (top_a < na) ka = na;
    if (top_b < nb) kb = nb;
    for (int i = 0; i < ka; i++) begin
      if ($urandom_range(7) == 0) send_beat(2'd3, $urandom);
      send_beat(FUNC_LOAD_A, pick_value());
    end
    for (int i = 0; i < kb; i++) send_beat(FUNC_LOAD_B, pick_value());
    if (broken && $urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 18)) send_beat(2'($urandom_range(1)), $urandom);
    end
    send_beat(FUNC_COMPUTE, $urandom);
  endtask

  task automatic random_shape();
    logic [2:0] ra, ca, rb, cb;
    logic [1:0] op;
    op = 2'($urandom_range(3));
    ra = 3'($urandom_range(1, 4));
    ca = 3'($urandom_range(1, 4));
    rb = 3'($urandom_range(1, 4));
    cb = 3'($urandom_range(1, 4));
    if ($urandom_range(3) != 0) begin
      case (op)
        OP_DET: begin
          ra = 3'($urandom_range(1, 3));
          ca = ra;
        end
        OP_MUL: rb = ca;
        default: begin
          rb = ra;
          cb = ca;
        end
      endcase
    end
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: ra = $urandom_range(1) ? 3'd0 : 3'd7;
        1: ca = 3'($urandom_range(5, 7));
        2: rb = 3'd0;
        default: cb = 3'($urandom_range(5, 7));
      endcase
    end
    set_shape(ra, ca, rb, cb, op);
  endtask

  initial begin
    rows_a = 3'd1;
    cols_a = 3'd1;
    rows_b = 3'd1;
    cols_b = 3'd1;
    op_sel = OP_ADD;
    fill_a = 0;
    fill_b = 0;
    top_a = 0;
    top_b = 0;
    beat_cnt = 0;
    hold_req = 1'b0;
    tx_idle_pct = 8;
    rx_idle_pct = 70;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: wrap on add, sub, mul; func 3; determinants; error cases
    send_beat(FUNC_LOAD_A, 32'h7fff_ffff);
    send_beat(FUNC_LOAD_B, 32'd1);
    send_beat(FUNC_COMPUTE, 32'hffff_ffff);
    set_shape(3'd1, 3'd1, 3'd1, 3'd1, OP_SUB);
    send_beat(FUNC_LOAD_A, 32'h8000_0000);
    send_beat(FUNC_LOAD_B, 32'd1);
    send_beat(2'd3, 32'h1234_5678);
    send_beat(FUNC_COMPUTE, 32'd0);
    set_shape(3'd1, 3'd1, 3'd1, 3'd1, OP_MUL);
    send_beat(FUNC_LOAD_A, 32'hffff_ffff);
    send_beat(FUNC_LOAD_B, 32'h8000_0000);
    send_beat(FUNC_COMPUTE, 32'd0);
    set_shape(3'd1, 3'd1, 3'd4, 3'd4, OP_DET);
    send_beat(FUNC_COMPUTE, 32'd0);
    set_shape(3'd2, 3'd2, 3'd1, 3'd1, OP_DET);
    for (int i = 0; i < 4; i++) send_beat(FUNC_LOAD_A, 32'h7fff_fff0 + i);
    send_beat(FUNC_COMPUTE, 32'd0);
    set_shape(3'd4, 3'd4, 3'd4, 3'd4, OP_DET);
    send_beat(FUNC_COMPUTE, 32'd0);
    set_shape(3'd2, 3'd3, 3'd2, 3'd3, OP_DET);
    send_beat(FUNC_COMPUTE, 32'd0);
    set_shape(3'd2, 3'd3, 3'd2, 3'd3, OP_MUL);
    send_beat(FUNC_COMPUTE, 32'd0);
    set_shape(3'd1, 3'd2, 3'd2, 3'd1, OP_ADD);
    send_beat(FUNC_COMPUTE, 32'd0);
    set_shape(3'd0, 3'd1, 3'd1, 3'd7, OP_ADD);
    send_beat(FUNC_COMPUTE, 32'd0);

    // fill both stores, overrun them, then random runs
    set_shape(3'd4, 3'd4, 3'd4, 3'd4, OP_ADD);
    repeat (18) send_beat(FUNC_LOAD_A, pick_value());
    repeat (17) send_beat(FUNC_LOAD_B, pick_value());
    send_beat(FUNC_COMPUTE, 32'd0);

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 70 : 0;
      rx_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 8 : 0;
      if (mode == 2) begin
        set_shape(3'd2, 3'd2, 3'd2, 3'd2, OP_MUL);
        matrix_run(1'b0);
        hold_req = 1'b1;
        matrix_run(1'b0);
        matrix_run(1'b0);
      end
      beat_cnt = 0;
      while (beat_cnt < 15) begin
        random_shape();
        repeat ($urandom_range(1, 2)) matrix_run($urandom_range(3) == 0);
      end
    end

    drain();
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
